// ===== rtl/mwsm_pkg.sv =====
package mwsm_pkg;

    localparam int DIGIT_W = 32;

    typedef logic [DIGIT_W-1:0] t_digit;

    // Operand select codes carried on the op input.
    localparam logic OP_A = 1'b0;
    localparam logic OP_B = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic   clear;
        logic   step;
        t_digit b;
    } t_cell_ctl;

endpackage

// ===== rtl/mwsm_cell.sv =====
module mwsm_cell (
    input  logic                i_clk,
    input  mwsm_pkg::t_cell_ctl i_ctl,
    input  logic                i_ld_a,
    input  logic                i_ld_b,
    input  mwsm_pkg::t_digit    i_digit,
    input  logic                i_a_en,
    input  mwsm_pkg::t_digit    i_s_next,
    input  mwsm_pkg::t_digit    i_b_next,
    output mwsm_pkg::t_digit    o_s,
    output mwsm_pkg::t_digit    o_b
);

    localparam int TW = 2 * mwsm_pkg::DIGIT_W;

    mwsm_pkg::t_digit r_a;
    mwsm_pkg::t_digit r_b;
    mwsm_pkg::t_digit r_s;
    mwsm_pkg::t_digit r_c;

    mwsm_pkg::t_digit w_a;
    logic [TW-1:0]    w_t;

    // Cells above the multiplicand length act as zero digits.
    assign w_a = i_a_en ? r_a : '0;

    // The sum cannot exceed the double-width range: (B-1)^2 + 2(B-1) = B^2 - 1.
    assign w_t = TW'(w_a) * TW'(i_ctl.b) + TW'(i_s_next) + TW'(r_c);

    always_ff @(posedge i_clk) begin
        if (i_ld_a) begin
            r_a <= i_digit;
        end
        if (i_ld_b) begin
            r_b <= i_digit;
        end else if (i_ctl.step) begin
            r_b <= i_b_next;
        end
        if (i_ctl.clear) begin
            r_s <= '0;
            r_c <= '0;
        end else if (i_ctl.step) begin
            r_s <= w_t[mwsm_pkg::DIGIT_W-1:0];
            r_c <= w_t[TW-1:mwsm_pkg::DIGIT_W];
        end
    end

    assign o_s = r_s;
    assign o_b = r_b;

endmodule

// ===== rtl/multiword_schoolbook_multiplier_top.sv =====
// Channel  | Handshake           | Payload ports
// ---------+---------------------+------------------------------------------------------
// input    | start, busy         | i_op, i_digit_value, i_last_digit
// result   | o_strobe            | o_product_digit, o_digit_index, o_product_length,
//          |                     | o_overflow_flag, o_last_result
//
// A digit that does not complete both operands is taken without raising busy. The transaction
// that completes them starts a busy run: P steps of the cell chain, P = len(a)+len(b) (one
// multiplier digit per step, then zeros), a flush state that writes the top digit, and P
// reads of the product memory; each result is registered from its read.
// Reset is synchronous and active low; it empties both operands and ends any run.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multiword_schoolbook_multiplier_top #(
    parameter int MAX_DIGITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [31:0] i_digit_value,
    input  logic        i_last_digit,
    output logic        o_strobe,
    output logic [31:0] o_product_digit,
    output logic [4:0]  o_digit_index,
    output logic [5:0]  o_product_length,
    output logic        o_overflow_flag,
    output logic        o_last_result
);

    localparam int CW    = $clog2(MAX_DIGITS + 1);
    localparam int PW    = $clog2(2 * MAX_DIGITS + 1);
    localparam int PROD  = 2 * MAX_DIGITS;
    localparam int IW    = (PROD > 1) ? $clog2(PROD) : 1;

    mwsm_pkg::t_state r_state;
    mwsm_pkg::t_state n_state;

    logic [CW-1:0] r_a_cnt, n_a_cnt;
    logic [CW-1:0] r_b_cnt, n_b_cnt;
    logic          r_a_done, n_a_done;
    logic          r_b_done, n_b_done;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_alen;
    logic [CW-1:0] r_blen;
    logic [PW-1:0] r_plen;
    logic          r_ovf;
    logic [PW-1:0] r_k, n_k;
    logic          r_wr_en;
    logic [IW-1:0] r_wr_idx;
    logic          r_top_nz;
    logic          r_o_vld;
    logic [IW-1:0] r_o_idx;
    logic          r_o_last;
    mwsm_pkg::t_digit r_rd_data;
    mwsm_pkg::t_digit r_prod_mem [PROD];

    logic          w_acc;
    logic          w_sel_done;
    logic [CW-1:0] w_sel_cnt;
    logic          w_take;
    logic          w_store;
    logic          w_fire;
    logic          w_step;
    logic          w_emit;
    logic          w_k_last;
    logic [PW-1:0] w_trim;

    mwsm_pkg::t_cell_ctl w_ctl;
    logic [MAX_DIGITS-1:0] w_ld_a;
    logic [MAX_DIGITS-1:0] w_ld_b;
    logic [MAX_DIGITS-1:0] w_a_en;
    mwsm_pkg::t_digit      w_s [MAX_DIGITS];
    mwsm_pkg::t_digit      w_b [MAX_DIGITS];

    // Operand loading.
    assign w_acc      = start && !busy;
    assign w_sel_done = (i_op == mwsm_pkg::OP_B) ? r_b_done : r_a_done;
    assign w_sel_cnt  = (i_op == mwsm_pkg::OP_B) ? r_b_cnt : r_a_cnt;
    assign w_take     = w_acc && !w_sel_done;
    assign w_store    = w_take && (w_sel_cnt < CW'(MAX_DIGITS));

    always_comb begin
        n_a_cnt  = r_a_cnt;
        n_b_cnt  = r_b_cnt;
        n_a_done = r_a_done;
        n_b_done = r_b_done;
        n_drop   = r_drop;
        if (w_take) begin
            if (i_op == mwsm_pkg::OP_B) begin
                n_b_cnt  = w_store ? r_b_cnt + CW'(1) : r_b_cnt;
                n_b_done = r_b_done || i_last_digit;
            end else begin
                n_a_cnt  = w_store ? r_a_cnt + CW'(1) : r_a_cnt;
                n_a_done = r_a_done || i_last_digit;
            end
            // A digit beyond the capacity is dropped but its end mark still counts.
            n_drop = r_drop || !w_store;
        end
    end

    assign w_fire   = w_take && n_a_done && n_b_done;
    assign w_k_last = (r_k == r_plen - PW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwsm_pkg::ST_IDLE: begin
                if (w_fire) begin
                    n_state = mwsm_pkg::ST_MUL;
                end
            end
            mwsm_pkg::ST_MUL: begin
                if (w_k_last) begin
                    n_state = mwsm_pkg::ST_FLUSH;
                end
            end
            mwsm_pkg::ST_FLUSH: begin
                n_state = mwsm_pkg::ST_EMIT;
            end
            mwsm_pkg::ST_EMIT: begin
                if (w_k_last) begin
                    n_state = mwsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mwsm_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        busy   = 1'b1;
        w_step = 1'b0;
        w_emit = 1'b0;
        case (r_state)
            mwsm_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            mwsm_pkg::ST_MUL: begin
                w_step = 1'b1;
            end
            mwsm_pkg::ST_FLUSH: begin
                w_step = 1'b0;
            end
            mwsm_pkg::ST_EMIT: begin
                w_emit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_k = r_k;
        if (w_fire) begin
            n_k = '0;
        end else if (w_step || w_emit) begin
            n_k = w_k_last ? '0 : r_k + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mwsm_pkg::ST_IDLE;
            r_a_cnt  <= '0;
            r_b_cnt  <= '0;
            r_a_done <= 1'b0;
            r_b_done <= 1'b0;
            r_drop   <= 1'b0;
            r_k      <= '0;
            r_wr_en  <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_wr_en <= w_step;
            r_o_vld <= w_emit;
            if (w_fire) begin
                r_a_cnt  <= '0;
                r_b_cnt  <= '0;
                r_a_done <= 1'b0;
                r_b_done <= 1'b0;
                r_drop   <= 1'b0;
            end else begin
                r_a_cnt  <= n_a_cnt;
                r_b_cnt  <= n_b_cnt;
                r_a_done <= n_a_done;
                r_b_done <= n_b_done;
                r_drop   <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_alen <= n_a_cnt;
            r_blen <= n_b_cnt;
            r_plen <= PW'(n_a_cnt) + PW'(n_b_cnt);
            r_ovf  <= n_drop;
        end
        r_wr_idx <= r_k[IW-1:0];
        r_o_idx  <= r_k[IW-1:0];
        r_o_last <= w_k_last;
    end

    // Cell chain. Multiplier digits ride down the chain toward cell 0, whose digit
    // is broadcast; after the multiplier is used up, zeros flush the partial sums out.
    always_comb begin
        w_ctl.clear = w_fire;
        w_ctl.step  = w_step;
        w_ctl.b     = (r_k < PW'(r_blen)) ? w_b[0] : '0;
    end

    for (genvar gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
        assign w_ld_a[gi] = w_store && (i_op == mwsm_pkg::OP_A) && (r_a_cnt == CW'(gi));
        assign w_ld_b[gi] = w_store && (i_op == mwsm_pkg::OP_B) && (r_b_cnt == CW'(gi));
        assign w_a_en[gi] = (CW'(gi) < r_alen);

        if (gi == MAX_DIGITS - 1) begin : g_end
            mwsm_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_ld_a   (w_ld_a[gi]),
                .i_ld_b   (w_ld_b[gi]),
                .i_digit  (i_digit_value),
                .i_a_en   (w_a_en[gi]),
                .i_s_next ('0),
                .i_b_next ('0),
                .o_s      (w_s[gi]),
                .o_b      (w_b[gi])
            );
        end else begin : g_mid
            mwsm_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_ld_a   (w_ld_a[gi]),
                .i_ld_b   (w_ld_b[gi]),
                .i_digit  (i_digit_value),
                .i_a_en   (w_a_en[gi]),
                .i_s_next (w_s[gi+1]),
                .i_b_next (w_b[gi+1]),
                .o_s      (w_s[gi]),
                .o_b      (w_b[gi])
            );
        end
    end

    // After each step cell 0 holds the next finished product digit.
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_prod_mem[r_wr_idx] <= w_s[0];
            if (r_wr_idx == IW'(r_plen - PW'(1))) begin
                r_top_nz <= (w_s[0] != '0);
            end
        end
        r_rd_data <= r_prod_mem[r_k[IW-1:0]];
    end

    assign w_trim = r_top_nz ? r_plen : r_plen - PW'(1);

    assign o_strobe         = r_o_vld;
    assign o_product_digit  = r_rd_data;
    assign o_digit_index    = 5'(r_o_idx);
    assign o_product_length = 6'(w_trim);
    assign o_overflow_flag  = r_ovf;
    assign o_last_result    = r_o_last;

endmodule
